FILE: design/msbs_pkg.sv
// ----------------------------------------------------------------------------
// msbs_pkg
// shared types and codes of the message buffer serializer
// ----------------------------------------------------------------------------
package msbs_pkg;

    localparam int unsigned BANKS = 8;
    localparam int unsigned MAX_COUNT = 8;

    typedef enum logic [2:0] {
        MODE_RESET  = 3'd0,
        MODE_SEEK   = 3'd1,
        MODE_APPEND = 3'd2,
        MODE_READ   = 3'd3,
        MODE_RAW    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FAULT = 2'd1,
        STATUS_SHORT = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] cursor;
        logic [11:0] fill_length;
        logic [2:0]  base;
        logic [3:0]  count;
        logic [3:0]  taken;
    } meta_t;

endpackage

FILE: design/msbs_ram.sv
// ----------------------------------------------------------------------------
// msbs_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module msbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 272
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/msbs_ctrl.sv
// ----------------------------------------------------------------------------
// msbs_ctrl
// cursor and length state, per-bank access requests for one request
// ----------------------------------------------------------------------------
module msbs_ctrl #(
    parameter int unsigned BUFFER_BYTES = 2176
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   fire,
    input  logic [2:0]                             mode,
    input  logic [3:0]                             byte_count,
    input  logic [63:0]                            write_value,
    input  logic [11:0]                            seek_position,
    output logic [msbs_pkg::BANKS-1:0]             wr_en,
    output logic [msbs_pkg::BANKS-1:0]             rd_en,
    output logic [msbs_pkg::BANKS-1:0][$clog2((BUFFER_BYTES+7)/8)-1:0] row,
    output logic [msbs_pkg::BANKS-1:0][7:0]        wr_data,
    output msbs_pkg::meta_t                        meta
);

    localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned ROW_W  = $clog2((BUFFER_BYTES + 7) / 8);
    localparam int unsigned CMP_W  = (ADDR_W > 12) ? ADDR_W : 12;
    localparam logic [ADDR_W-1:0] SIZE = ADDR_W'(BUFFER_BYTES);
    localparam logic [CMP_W-1:0]  SIZE_CMP = CMP_W'(BUFFER_BYTES);

    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [ADDR_W-1:0] length_reg, length_next;
    logic [ADDR_W-1:0] left_app, left_rd;
    logic [3:0]        count, taken;
    logic              append_go, read_go, raw_go;
    msbs_pkg::status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            length_reg <= '0;
        end else if (fire) begin
            cursor_reg <= cursor_next;
            length_reg <= length_next;
        end
    end

    always_comb begin
        count       = (byte_count > 4'(msbs_pkg::MAX_COUNT)) ? 4'(msbs_pkg::MAX_COUNT)
                                                             : byte_count;
        left_app    = (cursor_reg < SIZE) ? SIZE - cursor_reg : '0;
        left_rd     = (length_reg > cursor_reg) ? length_reg - cursor_reg : '0;
        cursor_next = cursor_reg;
        length_next = length_reg;
        status      = msbs_pkg::STATUS_OK;
        taken       = '0;
        append_go   = 1'b0;
        read_go     = 1'b0;
        raw_go      = 1'b0;
        unique case (msbs_pkg::mode_t'(mode))
            msbs_pkg::MODE_RESET: begin
                cursor_next = '0;
                length_next = '0;
            end
            msbs_pkg::MODE_SEEK: begin
                if (CMP_W'(seek_position) > SIZE_CMP) begin
                    status = msbs_pkg::STATUS_FAULT;
                end else begin
                    cursor_next = ADDR_W'(seek_position);
                    if (ADDR_W'(seek_position) > length_reg) begin
                        length_next = ADDR_W'(seek_position);
                    end
                end
            end
            msbs_pkg::MODE_APPEND: begin
                if (count != 4'd0) begin
                    append_go = 1'b1;
                    taken     = count;
                    if (left_app < ADDR_W'(count)) begin
                        status = msbs_pkg::STATUS_FAULT;
                        taken  = left_app[3:0];
                    end
                    cursor_next = cursor_reg + ADDR_W'(taken);
                    length_next = cursor_reg + ADDR_W'(taken);
                end
            end
            msbs_pkg::MODE_READ: begin
                if (count != 4'd0) begin
                    read_go = 1'b1;
                    taken   = count;
                    if (left_rd < ADDR_W'(count)) begin
                        status = msbs_pkg::STATUS_SHORT;
                        taken  = left_rd[3:0];
                    end
                    cursor_next = cursor_reg + ADDR_W'(taken);
                end
            end
            msbs_pkg::MODE_RAW: begin
                if (cursor_reg >= SIZE) begin
                    status = msbs_pkg::STATUS_FAULT;
                end else begin
                    raw_go      = 1'b1;
                    cursor_next = cursor_reg + ADDR_W'(1);
                    if (length_reg < SIZE) begin
                        length_next = length_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // bank b holds the byte at offset j of this request
    always_comb begin
        logic [2:0]      j;
        logic [2:0]      pos;
        logic [ADDR_W:0] addr_sum;
        for (int b = 0; b < msbs_pkg::BANKS; b++) begin
            j          = 3'(b) - cursor_reg[2:0];
            addr_sum   = (ADDR_W+1)'(cursor_reg) + (ADDR_W+1)'(j);
            pos        = 3'(count - 4'd1 - {1'b0, j});
            row[b]     = addr_sum[ROW_W+2:3];
            wr_data[b] = raw_go ? write_value[7:0] : 8'(write_value >> {pos, 3'b000});
            wr_en[b]   = (append_go && ({1'b0, j} < taken)) || (raw_go && (j == 3'd0));
            rd_en[b]   = read_go && ({1'b0, j} < taken);
        end
    end

    assign meta.status      = status;
    assign meta.cursor      = 12'(cursor_next);
    assign meta.fill_length = 12'(length_next);
    assign meta.base        = cursor_reg[2:0];
    assign meta.count       = count;
    assign meta.taken       = read_go ? taken : 4'd0;

endmodule

FILE: design/msbs_gather.sv
// ----------------------------------------------------------------------------
// msbs_gather
// assembles read bytes from the banks, most significant first, zero padded
// ----------------------------------------------------------------------------
module msbs_gather (
    input  msbs_pkg::meta_t                 meta,
    input  logic [msbs_pkg::BANKS-1:0][7:0] rdata,
    output logic [63:0]                     read_value
);

    always_comb begin
        logic [3:0] j;
        logic [2:0] bank;
        read_value = '0;
        for (int p = 0; p < msbs_pkg::BANKS; p++) begin
            j    = meta.count - 4'd1 - 4'(p);
            bank = meta.base + j[2:0];
            if ((4'(p) < meta.count) && (j < meta.taken)) begin
                read_value[8*p +: 8] = rdata[bank];
            end
        end
    end

endmodule

FILE: design/message_buffer_serializer.sv
// ----------------------------------------------------------------------------
// message_buffer_serializer
// byte message buffer with cursor and fill length, eight byte-wide banks
// pipeline: request registers, then bank read and meta registers, then output registers
// throughput: one request per cycle while m_ready does not hold the output, set by the single access per bank
// reset: cursor, length and pipeline valids cleared; byte store not cleared
// ----------------------------------------------------------------------------
module message_buffer_serializer #(
    parameter int unsigned BUFFER_BYTES = 2176
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [3:0]  s_byte_count,
    input  logic [63:0] s_write_value,
    input  logic [11:0] s_seek_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_read_value,
    output logic [1:0]  m_status,
    output logic [11:0] m_cursor,
    output logic [11:0] m_fill_length
);

    localparam int unsigned BANK_DEPTH = (BUFFER_BYTES + 7) / 8;
    localparam int unsigned ROW_W      = $clog2(BANK_DEPTH);

    logic        adv;
    logic        in_valid_reg;
    logic [2:0]  mode_reg;
    logic [3:0]  count_reg;
    logic [63:0] wval_reg;
    logic [11:0] spos_reg;
    logic        fire;

    logic [msbs_pkg::BANKS-1:0]             wr_en, rd_en;
    logic [msbs_pkg::BANKS-1:0][ROW_W-1:0]  row;
    logic [msbs_pkg::BANKS-1:0][7:0]        wr_data, rdata;
    msbs_pkg::meta_t                        meta_next, meta_reg;
    logic                                   s2_valid_reg;
    logic [63:0]                            read_value;

    logic        out_valid_reg;
    logic [63:0] out_read_value_reg;
    logic [1:0]  out_status_reg;
    logic [11:0] out_cursor_reg;
    logic [11:0] out_fill_length_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv || !in_valid_reg;
    assign fire    = adv && in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                s2_valid_reg  <= in_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            mode_reg  <= s_mode;
            count_reg <= s_byte_count;
            wval_reg  <= s_write_value;
            spos_reg  <= s_seek_position;
        end
        if (fire) begin
            meta_reg <= meta_next;
        end
        if (adv && s2_valid_reg) begin
            out_read_value_reg  <= read_value;
            out_status_reg      <= meta_reg.status;
            out_cursor_reg      <= meta_reg.cursor;
            out_fill_length_reg <= meta_reg.fill_length;
        end
    end

    msbs_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .mode          (mode_reg),
        .byte_count    (count_reg),
        .write_value   (wval_reg),
        .seek_position (spos_reg),
        .wr_en         (wr_en),
        .rd_en         (rd_en),
        .row           (row),
        .wr_data       (wr_data),
        .meta          (meta_next)
    );

    for (genvar b = 0; b < msbs_pkg::BANKS; b++) begin : g_bank
        msbs_ram #(
            .WIDTH(8),
            .DEPTH(BANK_DEPTH)
        ) u_bank (
            .aclk  (aclk),
            .en    (fire && (wr_en[b] || rd_en[b])),
            .we    (wr_en[b]),
            .addr  (row[b]),
            .wdata (wr_data[b]),
            .rdata (rdata[b])
        );
    end

    msbs_gather u_gather (
        .meta       (meta_reg),
        .rdata      (rdata),
        .read_value (read_value)
    );

    assign m_valid       = out_valid_reg;
    assign m_read_value  = out_read_value_reg;
    assign m_status      = out_status_reg;
    assign m_cursor      = out_cursor_reg;
    assign m_fill_length = out_fill_length_reg;

endmodule
